// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked at each rising edge, ignored while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at each rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/gmd_pkg.sv =====
// ---------------------------------------------------------------------------
// gmd_pkg
// types and constants shared by the genetic map distance block
// ---------------------------------------------------------------------------
package gmd_pkg;

  localparam int MAP_DEPTH_DEF = 4096;

  localparam int IDX_W  = 12;
  localparam int POS_W  = 31;
  localparam int RATE_W = 32;
  localparam int DIST_W = 63;
  localparam int CNT_W  = 13;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CHK,
    S_ACC_RD,
    S_ACC_LO,
    S_ACC_HI,
    S_MUL,
    S_ADD,
    S_DONE
  } gmd_state_t;

  // controls for the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic rate_load;
    logic span_load;
    logic mul_en;
    logic acc_en;
  } gmd_mac_ctrl_t;

endpackage

// ===== sv/gmd_map_mem.sv =====
// ---------------------------------------------------------------------------
// gmd_map_mem
// recombination map storage: one write port, one registered read port
// ---------------------------------------------------------------------------
module gmd_map_mem #(
  parameter int MAP_DEPTH = gmd_pkg::MAP_DEPTH_DEF,
  parameter int AW        = $clog2(MAP_DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [gmd_pkg::POS_W-1:0]  wpos,
  input  logic [gmd_pkg::RATE_W-1:0] wrate,
  input  logic [AW-1:0]             raddr,
  output logic [gmd_pkg::POS_W-1:0]  rpos,
  output logic [gmd_pkg::RATE_W-1:0] rrate
);
  import gmd_pkg::*;

  logic [POS_W-1:0]  pos_mem  [MAP_DEPTH];
  logic [RATE_W-1:0] rate_mem [MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      pos_mem[waddr]  <= wpos;
      rate_mem[waddr] <= wrate;
    end
  end

  always_ff @(posedge clk) begin
    rpos  <= pos_mem[raddr];
    rrate <= rate_mem[raddr];
  end

endmodule

// ===== sv/gmd_mac.sv =====
// ---------------------------------------------------------------------------
// gmd_mac
// shared span, multiply and saturating accumulate unit
// ---------------------------------------------------------------------------
module gmd_mac (
  input  logic                      clk,
  input  gmd_pkg::gmd_mac_ctrl_t    ctrl,
  input  logic [gmd_pkg::POS_W-1:0]  lo,
  input  logic [gmd_pkg::POS_W-1:0]  hi,
  input  logic [gmd_pkg::RATE_W-1:0] rate,
  output logic [gmd_pkg::DIST_W-1:0] acc
);
  import gmd_pkg::*;

  logic [POS_W-1:0]  span_r;
  logic [RATE_W-1:0] rate_r;
  logic [DIST_W-1:0] prod_r;
  logic [DIST_W:0]   sum;

  // sum stays below 2^64 since both terms are below 2^63
  assign sum = {1'b0, acc} + {1'b0, prod_r};

  always_ff @(posedge clk) begin
    if (ctrl.rate_load) begin
      rate_r <= rate;
    end
    if (ctrl.span_load) begin
      span_r <= (hi > lo) ? hi - lo : '0;
    end
    if (ctrl.mul_en) begin
      // full 31 x 32 bit product, always below 2^63
      prod_r <= DIST_W'(span_r) * DIST_W'(rate_r);
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    end
  end

endmodule

// ===== sv/genetic_map_distance.sv =====
// ---------------------------------------------------------------------------
// genetic_map_distance
// recombination map lookup and piecewise linear distance over a span
// ---------------------------------------------------------------------------
// write item: stored in the map, the block stays ready, no result
// query: the scan reads each map entry in turn (S_SCAN, S_CHK) up to the end bin + 1,
//   then sums each bin (S_ACC_RD, S_ACC_LO, S_ACC_HI, S_MUL, S_ADD; the end bin skips
//   S_ACC_HI); one shared multiplier and one memory read port; reversed order goes straight to S_DONE
// one item at a time; ready only while idle
// rst (synchronous) clears control state, map_count returns to 1, map unwritten
module genetic_map_distance #(
  parameter int MAP_DEPTH = gmd_pkg::MAP_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write channel: map_count
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gmd_pkg::CNT_W-1:0]    cfg_data,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // entry_index[11:0], entry_position[42:12], entry_rate[74:43],
  // query_start[105:75], query_end[136:106], zero fill[143:137]
  input  logic [143:0]                s_tdata,
  // func[0]
  input  logic                        s_tuser,
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // distance[62:0], zero fill[63]
  output logic [63:0]                 m_tdata,
  // order_error[0]
  output logic                        m_tuser
);
  import gmd_pkg::*;

  localparam int AW = $clog2(MAP_DEPTH);
  // wide enough for the count register and for MAP_DEPTH itself
  localparam int CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

  // input field slices
  logic [IDX_W-1:0]  in_index;
  logic [POS_W-1:0]  in_pos;
  logic [RATE_W-1:0] in_rate;
  logic [POS_W-1:0]  in_start;
  logic [POS_W-1:0]  in_end;

  assign in_index = s_tdata[11:0];
  assign in_pos   = s_tdata[42:12];
  assign in_rate  = s_tdata[74:43];
  assign in_start = s_tdata[105:75];
  assign in_end   = s_tdata[136:106];

  gmd_state_t state, state_next;

  logic [CNT_W-1:0] map_count;
  logic [POS_W-1:0] q_start;
  logic [POS_W-1:0] q_end;
  logic             err_r;
  logic [AW-1:0]    idx;      // scan position
  logic             found_s;  // start bin already located
  logic [AW-1:0]    bin_lo;
  logic [AW-1:0]    bin_hi;
  logic [AW-1:0]    k;        // bin being summed
  logic [POS_W-1:0] lo_r;

  logic              in_xfer;
  logic              wr_item;
  logic              mem_we;
  logic [AW-1:0]     rd_addr;
  logic [POS_W-1:0]  pos_q;
  logic [RATE_W-1:0] rate_q;

  gmd_mac_ctrl_t     mac_ctrl;
  logic [POS_W-1:0]  mac_lo;
  logic [POS_W-1:0]  mac_hi;
  logic [DIST_W-1:0] acc;

  logic [CW-1:0]     cnt_w;
  logic [AW-1:0]     last_idx;
  logic [AW-1:0]     prev;
  logic              hit_s;
  logic              hit_e;
  logic [AW-1:0]     lo_sel;
  logic [POS_W-1:0]  lo_now;
  logic              out_load;

  // config port is always open; writes must only come while idle, the block itself does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_count <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      map_count <= cfg_data;
    end
  end

  // last valid map index: a count of zero acts as one, large counts clamp
  assign cnt_w = CW'(map_count);
  always_comb begin
    if (cnt_w == '0) begin
      last_idx = '0;
    end else if (cnt_w > CW'(MAP_DEPTH)) begin
      last_idx = AW'(MAP_DEPTH - 1);
    end else begin
      last_idx = AW'(cnt_w - CW'(1));
    end
  end

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign wr_item  = in_xfer && (s_tuser == FUNC_WRITE);
  // slots beyond the map depth are dropped
  assign mem_we   = wr_item && (CW'(in_index) < CW'(MAP_DEPTH));

  // map memory read address follows the sequencer
  always_comb begin
    unique case (state)
      S_SCAN:   rd_addr = idx;
      S_ACC_LO: rd_addr = k + AW'(1);
      default:  rd_addr = k;
    endcase
  end

  gmd_map_mem #(
    .MAP_DEPTH (MAP_DEPTH),
    .AW        (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_index)),
    .wpos  (in_pos),
    .wrate (in_rate),
    .raddr (rd_addr),
    .rpos  (pos_q),
    .rrate (rate_q)
  );

  // scan compare: bin is the entry just before the first one above the position
  assign prev   = (idx == '0) ? '0 : idx - AW'(1);
  assign hit_s  = !found_s && (pos_q > q_start);
  assign hit_e  = pos_q > q_end;
  assign lo_sel = hit_s ? prev : (found_s ? bin_lo : last_idx);

  // low end of the current bin: query start for the first bin
  assign lo_now = (k == bin_lo) ? q_start : pos_q;

  // shared unit operands: end bin uses the query end, others the next entry
  assign mac_lo = (state == S_ACC_HI) ? lo_r : lo_now;
  assign mac_hi = (state == S_ACC_HI) ? pos_q : q_end;

  gmd_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .lo   (mac_lo),
    .hi   (mac_hi),
    .rate (rate_q),
    .acc  (acc)
  );

  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit controls
  always_comb begin
    state_next = state;
    mac_ctrl   = '0;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && (s_tuser == FUNC_QUERY)) begin
          mac_ctrl.clear = 1'b1;
          state_next = (in_start > in_end) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        if (hit_e || (idx == last_idx)) begin
          state_next = S_ACC_RD;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_ACC_RD: begin
        state_next = S_ACC_LO;
      end
      S_ACC_LO: begin
        mac_ctrl.rate_load = 1'b1;
        if (k == bin_hi) begin
          mac_ctrl.span_load = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_ACC_HI;
        end
      end
      S_ACC_HI: begin
        mac_ctrl.span_load = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        mac_ctrl.acc_en = 1'b1;
        state_next = (k == bin_hi) ? S_DONE : S_ACC_RD;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // query payload and sequencer counters
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_xfer) begin
      q_start <= in_start;
      q_end   <= in_end;
      err_r   <= in_start > in_end;
      idx     <= '0;
    end
    if (rst) begin
      found_s <= 1'b0;
    end else if (state == S_IDLE) begin
      found_s <= 1'b0;
    end else if (state == S_CHK && hit_s) begin
      found_s <= 1'b1;
    end
    if (state == S_CHK) begin
      if (hit_e) begin
        // an entry above the end also lies above the start
        bin_hi <= prev;
        bin_lo <= lo_sel;
        k      <= lo_sel;
      end else if (idx == last_idx) begin
        bin_hi <= last_idx;
        bin_lo <= lo_sel;
        k      <= lo_sel;
      end else begin
        if (hit_s) begin
          bin_lo <= prev;
        end
        idx <= idx + AW'(1);
      end
    end
    if (state == S_ACC_LO) begin
      lo_r <= lo_now;
    end
    if (state == S_ADD && k != bin_hi) begin
      k <= k + AW'(1);
    end
  end

  // result register, parts the sequencer from the downstream side
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, acc};
      m_tuser <= err_r;
    end
  end

  `include "assert_macros.svh"

  // a reversed span reports zero distance
  `ASSERT_CLK(a_err_zero, clk, rst, (m_tvalid && m_tuser) |-> (m_tdata == '0), "error with distance")
  // bin summation stays between the start and end bins
  `ASSERT_CLK(a_k_range, clk, rst, (state == S_ACC_RD) |-> (k >= bin_lo && k <= bin_hi), "bin out of range")
  // the scan never passes the last valid entry
  `ASSERT_CLK(a_scan_end, clk, rst, (state == S_SCAN) |-> (idx <= last_idx), "scan past map end")
  // accumulation never decreases within a query
  `ASSERT_CLK(a_acc_mono, clk, rst, (state == S_ADD) |=> (acc >= $past(acc)), "sum decreased")

endmodule
